// ===== design/csa_pkg.sv =====
`default_nettype none

package csa_pkg;

  // Row geometry and owner width
  localparam int unsigned NUM_SLOTS  = 8;
  localparam int unsigned OWNER_BITS = 8;

  // Owner bits kept per slot: the low OWNER_BITS of the 8-bit owner field
  localparam int unsigned OWN_W = (OWNER_BITS < 8) ? OWNER_BITS : 8;

  // Slot index and run counter widths
  localparam int unsigned IDX_W = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
  localparam int unsigned RUN_W = $clog2(NUM_SLOTS + 1);

  // Saturation limit of the freed slot count
  localparam logic [3:0] FREED_MAX = 4'd15;

  typedef enum logic [0:0] {
    CMD_RESERVE = 1'b0,
    CMD_RELEASE = 1'b1
  } csa_command_e;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_NO_FIT  = 2'd1,
    ST_INVALID = 2'd2
  } csa_status_e;

  typedef struct packed {
    csa_command_e command;
    logic [7:0]   owner_id;
    logic [3:0]   run_length;
  } csa_in_t;

  typedef struct packed {
    csa_status_e status;
    logic [2:0]  start_slot;
    logic [3:0]  freed_count;
  } csa_out_t;

  // Commands from the controller to the datapath
  typedef struct packed {
    logic load;
    logic step;
    logic load_result;
  } csa_ctrl_t;

  // Status from the datapath to the controller
  typedef struct packed {
    logic is_release;
    logic len_bad;
    logic hit;
    logic last;
  } csa_stat_t;

endpackage

`default_nettype wire

// ===== design/csa_datapath.sv =====
`default_nettype none

module csa_datapath import csa_pkg::*; (
  input  wire logic      clk_i,
  input  wire logic      rst_ni,
  input  wire csa_in_t   in_i,
  input  wire csa_ctrl_t ctrl_i,
  output csa_stat_t      stat_o,
  output csa_out_t       out_o
);

  // Captured transaction
  csa_command_e     cmd_q;
  logic [OWN_W-1:0] owner_q;
  logic [3:0]       len_q;

  // Scan state
  logic [IDX_W-1:0] idx_q;
  logic [RUN_W-1:0] run_q;
  logic [IDX_W-1:0] start_q;
  logic             found_q;
  logic [3:0]       freed_q;

  // Slot row
  logic [NUM_SLOTS-1:0] busy_q;
  logic [OWN_W-1:0]     owner_mem_q [NUM_SLOTS];

  csa_out_t out_q;

  logic             busy_cur;
  logic [OWN_W-1:0] owner_cur;
  logic             match;
  logic             hit;
  logic             len_bad;
  logic             last;
  logic [IDX_W-1:0] start_d;
  logic [NUM_SLOTS-1:0] commit_mask;
  csa_out_t         result_d;

  // Look at the slot under the scan pointer
  assign busy_cur  = busy_q[idx_q];
  assign owner_cur = owner_mem_q[idx_q];
  assign match     = busy_cur && (owner_cur == owner_q);
  assign len_bad   = (len_q == 4'd0) || (32'(len_q) > NUM_SLOTS);
  assign last      = (idx_q == IDX_W'(NUM_SLOTS - 1));
  assign hit       = (cmd_q == CMD_RESERVE) && !busy_cur &&
                     ((32'(run_q) + 32'd1) == 32'(len_q));
  assign start_d   = IDX_W'(32'(idx_q) + 32'd1 - 32'(len_q));

  // Mark the slots of the run that ends at the scan pointer
  always_comb begin
    for (int s = 0; s < NUM_SLOTS; s++) begin
      commit_mask[s] = (IDX_W'(s) >= start_d) && (IDX_W'(s) <= idx_q);
    end
  end

  assign stat_o.is_release = (cmd_q == CMD_RELEASE);
  assign stat_o.len_bad    = len_bad;
  assign stat_o.hit        = hit;
  assign stat_o.last       = last;

  // Form the result from the finished scan
  always_comb begin
    result_d.status      = ST_OK;
    result_d.start_slot  = 3'd0;
    result_d.freed_count = 4'd0;
    if (cmd_q == CMD_RELEASE) begin
      result_d.freed_count = freed_q;
    end else if (len_bad) begin
      result_d.status = ST_INVALID;
    end else if (found_q) begin
      result_d.start_slot = 3'(start_q);
    end else begin
      result_d.status = ST_NO_FIT;
    end
  end

  // Advance the scan and update the busy flags
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q   <= '0;
      run_q   <= '0;
      found_q <= 1'b0;
      freed_q <= 4'd0;
      busy_q  <= '0;
    end else if (ctrl_i.load) begin
      idx_q   <= '0;
      run_q   <= '0;
      found_q <= 1'b0;
      freed_q <= 4'd0;
    end else if (ctrl_i.step) begin
      idx_q <= idx_q + 1'b1;
      if (cmd_q == CMD_RESERVE) begin
        run_q <= busy_cur ? '0 : run_q + 1'b1;
        if (hit) begin
          found_q <= 1'b1;
          busy_q  <= busy_q | commit_mask;
        end
      end else if (match) begin
        busy_q[idx_q] <= 1'b0;
        if (freed_q != FREED_MAX) begin
          freed_q <= freed_q + 4'd1;
        end
      end
    end
  end

  // Hold the transaction, owners and result
  always_ff @(posedge clk_i) begin
    if (ctrl_i.load) begin
      cmd_q   <= in_i.command;
      owner_q <= in_i.owner_id[OWN_W-1:0];
      len_q   <= in_i.run_length;
    end
    if (ctrl_i.step && hit) begin
      start_q <= start_d;
      for (int s = 0; s < NUM_SLOTS; s++) begin
        if (commit_mask[s]) begin
          owner_mem_q[s] <= owner_q;
        end
      end
    end
    if (ctrl_i.load_result) begin
      out_q <= result_d;
    end
  end

  assign out_o = out_q;

endmodule

`default_nettype wire

// ===== design/csa_controller.sv =====
`default_nettype none

module csa_controller import csa_pkg::*; (
  input  wire logic      clk_i,
  input  wire logic      rst_ni,
  input  wire logic      in_valid_i,
  output logic           in_ready_o,
  output logic           out_valid_o,
  input  wire logic      out_ready_i,
  input  wire csa_stat_t stat_i,
  output csa_ctrl_t      ctrl_o
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_DONE
  } state_e;

  state_e state_q, state_d;
  logic   out_valid_q;
  logic   stop_early;

  // Drop out of the scan on a bad length or a fitting run
  assign stop_early = !stat_i.is_release && (stat_i.len_bad || stat_i.hit);

  // Issue datapath commands
  always_comb begin
    ctrl_o.load        = (state_q == S_IDLE) && in_valid_i;
    ctrl_o.step        = (state_q == S_SCAN) && !(!stat_i.is_release && stat_i.len_bad);
    ctrl_o.load_result = (state_q == S_DONE) && (!out_valid_q || out_ready_i);
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) state_d = S_SCAN;
      end
      S_SCAN: begin
        if (stop_early || stat_i.last) state_d = S_DONE;
      end
      S_DONE: begin
        if (ctrl_o.load_result) state_d = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  // Hold state and the result valid flag
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (ctrl_o.load_result) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign in_ready_o  = (state_q == S_IDLE);
  assign out_valid_o = out_valid_q;

endmodule

`default_nettype wire

// ===== design/contiguous_slot_allocator_unit.sv =====
`default_nettype none

// First-fit allocator over a row of NUM_SLOTS slots. A reserve transaction
// finds the lowest run of run_length adjacent free slots, marks it with the
// owner and returns its start slot; a release transaction frees every slot
// of the owner and returns how many it freed. One transaction is processed
// at a time by scanning one slot per cycle. A reserve stops at the slot that
// completes the run, a release always scans the whole row, and a reserve
// with an invalid length goes to its result without scanning a slot. The
// result sits in an output register, so a new transaction is accepted while
// the previous result waits to be taken; its own result is held until then.
module contiguous_slot_allocator_unit import csa_pkg::*; (
  input  wire logic    clk_i,
  input  wire logic    rst_ni,
  input  wire logic    in_valid_i,
  output logic         in_ready_o,
  input  wire csa_in_t in_i,
  output logic         out_valid_o,
  input  wire logic    out_ready_i,
  output csa_out_t     out_o
);

  csa_ctrl_t ctrl;
  csa_stat_t stat;

  csa_controller u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .stat_i      (stat),
    .ctrl_o      (ctrl)
  );

  csa_datapath u_dp (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_i),
    .ctrl_i (ctrl),
    .stat_o (stat),
    .out_o  (out_o)
  );

`ifndef NO_ASSERTIONS
  // An accepted transaction blocks the input until its result is registered
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !in_ready_o)
    else $error("input ready right after an accepted transaction");

  // A failed reserve reports start slot zero
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (out_o.status != ST_OK) |-> (out_o.start_slot == 3'd0))
    else $error("non-zero start slot on a failed reserve");

  // Only release results carry a freed count, and they are always ok
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (out_o.freed_count != 4'd0) |->
      (out_o.status == ST_OK) && (out_o.start_slot == 3'd0))
    else $error("freed count on a result that is not a release");
`endif

endmodule

`default_nettype wire

// ===== tb/contiguous_slot_allocator_checker.sv =====
`default_nettype none

// Watches both channels of the slot allocator, keeps its own copy of the slot
// row, works out the reply to every accepted request and compares each
// accepted reply against the oldest outstanding prediction.
module contiguous_slot_allocator_checker import csa_pkg::*; (
  input  wire logic     clk_i,
  input  wire logic     rst_ni,
  input  wire logic     in_valid_i,
  input  wire logic     in_ready_i,
  input  wire csa_in_t  in_i,
  input  wire logic     out_valid_i,
  input  wire logic     out_ready_i,
  input  wire csa_out_t out_i,
  output int            mismatch_cnt_o,
  output int            pending_o,
  output int            checked_o,
  output int            no_fit_o,
  output int            invalid_o
);

  localparam int MaxReports = 10;

  // Shadow copy of the slot row
  logic             slot_taken [NUM_SLOTS];
  logic [OWN_W-1:0] slot_holder [NUM_SLOTS];

  // Replies predicted but not yet seen on the output channel
  csa_out_t expected_replies [$];

  // Apply one request to the shadow row and return the reply it causes
  function automatic csa_out_t predict_allocation(csa_in_t req);
    csa_out_t         reply;
    int               run;
    int               first;
    int               i;
    logic [3:0]       freed;
    logic [OWN_W-1:0] who;

    reply = '0;
    reply.status = ST_OK;
    who = req.owner_id[OWN_W-1:0];
    freed = '0;
    if (req.command == CMD_RESERVE) begin
      if (req.run_length == 0 || req.run_length > NUM_SLOTS) begin
        reply.status = ST_INVALID;
      end else begin
        // First fit: lowest start of a free run of the wanted length
        run = 0;
        first = -1;
        for (i = 0; i < NUM_SLOTS; i++) begin
          if (!slot_taken[i]) begin
            run++;
            if (run == req.run_length && first < 0) begin
              first = i + 1 - run;
            end
          end else begin
            run = 0;
          end
        end
        if (first < 0) begin
          reply.status = ST_NO_FIT;
        end else begin
          for (i = first; i < first + req.run_length; i++) begin
            slot_taken[i] = 1'b1;
            slot_holder[i] = who;
          end
          reply.start_slot = 3'(first);
        end
      end
    end else begin
      // Release every slot of the owner, counting with saturation
      for (i = 0; i < NUM_SLOTS; i++) begin
        if (slot_taken[i] && slot_holder[i] == who) begin
          slot_taken[i] = 1'b0;
          if (freed < FREED_MAX) begin
            freed++;
          end
        end
      end
      reply.freed_count = freed;
    end
    return reply;
  endfunction

  // Report the first few failures in full, count the rest
  function automatic void note_failure(string what, csa_out_t exp_r, csa_out_t act_r);
    mismatch_cnt_o++;
    if (mismatch_cnt_o <= MaxReports) begin
      $display("ERROR: %s: expected status %0d start %0d freed %0d, got status %0d start %0d freed %0d",
               what, exp_r.status, exp_r.start_slot, exp_r.freed_count,
               act_r.status, act_r.start_slot, act_r.freed_count);
    end
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    csa_out_t exp_r;
    int       i;

    if (!rst_ni) begin
      for (i = 0; i < NUM_SLOTS; i++) begin
        slot_taken[i] = 1'b0;
        slot_holder[i] = '0;
      end
      expected_replies.delete();
      mismatch_cnt_o = 0;
      pending_o = 0;
      checked_o = 0;
      no_fit_o = 0;
      invalid_o = 0;
    end else begin
      // Check the reply first: it always belongs to an earlier request
      if (out_valid_i && out_ready_i) begin
        if (expected_replies.size() == 0) begin
          note_failure("reply with no request outstanding", '0, out_i);
        end else begin
          exp_r = expected_replies.pop_front();
          checked_o++;
          if (exp_r.status == ST_NO_FIT) no_fit_o++;
          if (exp_r.status == ST_INVALID) invalid_o++;
          if (out_i.status != exp_r.status || out_i.start_slot != exp_r.start_slot ||
              out_i.freed_count != exp_r.freed_count) begin
            note_failure("reply mismatch", exp_r, out_i);
          end
        end
      end
      // Predict the reply of a newly accepted request
      if (in_valid_i && in_ready_i) begin
        expected_replies.push_back(predict_allocation(in_i));
      end
      pending_o = expected_replies.size();
    end
  end

endmodule

`default_nettype wire

// ===== tb/contiguous_slot_allocator_unit_test.sv =====
`default_nettype none

module contiguous_slot_allocator_unit_test;
  import csa_pkg::*;

  localparam int ResetCycles  = 7;
  localparam int RandomItems  = 1780;
  localparam int OwnerPool    = 6;
  localparam int HoldCycles   = 300;
  localparam int IdleLimit    = 3000;
  localparam int DrainCycles  = NUM_SLOTS + 6;

  logic     clk_i;
  logic     rst_ni;
  logic     in_valid_i;
  logic     in_ready_o;
  csa_in_t  in_i;
  logic     out_valid_o;
  logic     out_ready_i;
  csa_out_t out_o;

  int mismatch_cnt;
  int pending;
  int checked;
  int no_fit_seen;
  int invalid_seen;

  int  reserves_sent;
  int  releases_sent;
  int  idle_cycles;
  bit  calm;
  bit  hold_done;

  contiguous_slot_allocator_unit i_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_i       (in_i),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .out_o      (out_o)
  );

  contiguous_slot_allocator_checker i_checker (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_ready_i    (in_ready_o),
    .in_i          (in_i),
    .out_valid_i   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .out_i         (out_o),
    .mismatch_cnt_o(mismatch_cnt),
    .pending_o     (pending),
    .checked_o     (checked),
    .no_fit_o      (no_fit_seen),
    .invalid_o     (invalid_seen)
  );

  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  // Mostly no gap, often a short one, now and then a long one
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (calm || r < 60) return 0;
    if (r < 90) return $urandom_range(1, 4);
    return $urandom_range(10, 40);
  endfunction

  // Offer one request, hold it until accepted, return at a falling edge
  task automatic send_request(csa_command_e cmd, logic [7:0] owner, logic [3:0] len);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_i <= '{command: cmd, owner_id: owner, run_length: len};
    if (cmd == CMD_RESERVE) reserves_sent++;
    else releases_sent++;
    do @(posedge clk_i); while (!in_ready_o);
    @(negedge clk_i);
  endtask

  // Receiver: random back-pressure, plus one long hold-off to fill the block
  initial begin
    int gap;
    out_ready_i = 1'b0;
    hold_done = 1'b0;
    @(posedge rst_ni);
    forever begin
      @(negedge clk_i);
      if (!hold_done && checked >= 30) begin
        out_ready_i <= 1'b0;
        repeat (HoldCycles) @(negedge clk_i);
        hold_done = 1'b1;
      end
      gap = pick_gap();
      if (gap > 0) begin
        out_ready_i <= 1'b0;
        repeat (gap) @(negedge clk_i);
      end
      out_ready_i <= 1'b1;
    end
  end

  // Watchdog: end the run when nothing moves for too long
  always @(posedge clk_i) begin
    if (!rst_ni || (in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IdleLimit) begin
      $display("Watchdog: no transaction for %0d cycles, %0d replies outstanding",
               idle_cycles, pending);
      $display("Testbench completed WITH ERRORS");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // Stimulus and verdict
  initial begin
    logic [7:0] owner_pool [OwnerPool];
    logic [7:0] who;
    int         n;
    int         k;
    int         pick;

    rst_ni = 1'b0;
    in_valid_i = 1'b0;
    in_i = '0;
    calm = 1'b0;
    reserves_sent = 0;
    releases_sent = 0;
    idle_cycles = 0;
    repeat (ResetCycles) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // Invalid lengths: zero, one past the row and every bit set
    send_request(CMD_RESERVE, 8'h00, 4'd0);
    send_request(CMD_RESERVE, 8'h00, 4'(NUM_SLOTS + 1));
    send_request(CMD_RESERVE, 8'hFF, 4'd15);
    // Release of an owner that holds nothing, with a stray length
    send_request(CMD_RELEASE, 8'h5A, 4'd15);
    // Fill the whole row, then a reserve that cannot fit, then free the row
    send_request(CMD_RESERVE, 8'hFF, 4'(NUM_SLOTS));
    send_request(CMD_RESERVE, 8'h01, 4'd1);
    send_request(CMD_RELEASE, 8'hFF, 4'd0);
    // Fragment the row and probe first fit around the hole
    send_request(CMD_RESERVE, 8'h11, 4'd3);
    send_request(CMD_RESERVE, 8'h22, 4'd2);
    send_request(CMD_RESERVE, 8'h11, 4'd3);
    send_request(CMD_RELEASE, 8'h22, 4'd7);
    send_request(CMD_RESERVE, 8'h33, 4'd3);
    send_request(CMD_RESERVE, 8'h33, 4'd2);
    send_request(CMD_RELEASE, 8'h11, 4'd0);
    send_request(CMD_RESERVE, 8'hAA, 4'd4);
    send_request(CMD_RESERVE, 8'h00, 4'd1);
    send_request(CMD_RESERVE, 8'h00, 4'd7);
    send_request(CMD_RELEASE, 8'h00, 4'd1);
    send_request(CMD_RELEASE, 8'h33, 4'd8);
    // Run ending on the top slot
    send_request(CMD_RESERVE, 8'h80, 4'd5);
    send_request(CMD_RESERVE, 8'h80, 4'd3);
    send_request(CMD_RELEASE, 8'h80, 4'd0);

    // Random traffic: a small owner pool so that releases find their slots
    for (n = 0; n < RandomItems; n++) begin
      if (n % 300 == 0) begin
        for (k = 0; k < OwnerPool; k++) owner_pool[k] = 8'($urandom_range(0, 255));
      end
      calm = ((n / 150) % 4) == 3;
      pick = $urandom_range(0, 99);
      who = owner_pool[$urandom_range(0, OwnerPool - 1)];
      if (pick < 55) begin
        send_request(CMD_RESERVE, who, ($urandom_range(0, 9) == 0) ?
                     4'($urandom_range(1, NUM_SLOTS)) : 4'($urandom_range(1, 3)));
      end else if (pick < 83) begin
        send_request(CMD_RELEASE, who, 4'($urandom_range(0, 15)));
      end else if (pick < 91) begin
        send_request(CMD_RESERVE, who, $urandom_range(0, 1) ?
                     4'd0 : 4'($urandom_range(NUM_SLOTS + 1, 15)));
      end else if (pick < 95) begin
        send_request(CMD_RELEASE, 8'($urandom_range(0, 255)), 4'($urandom_range(0, 15)));
      end else begin
        send_request(csa_command_e'(1'($urandom_range(0, 1))),
                     8'($urandom_range(0, 255)), 4'($urandom_range(0, 15)));
      end
    end
    in_valid_i <= 1'b0;
    calm = 1'b1;

    // Drain: wait for every reply, then a little longer for strays
    wait (pending == 0);
    repeat (DrainCycles) @(posedge clk_i);

    $display("Run covered %0d reserve and %0d release requests, %0d replies checked",
             reserves_sent, releases_sent, checked);
    $display("  of which %0d no-fit and %0d invalid-length, with a %0d-cycle receiver hold-off",
             no_fit_seen, invalid_seen, HoldCycles);
    if (mismatch_cnt == 0 && pending == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

`default_nettype wire
